/* rtl/kci_pkg.sv */
// Shared constants and types of the keyframe curve interpolator.
package kci_pkg;

    localparam int MaxPoints = 64;
    localparam int AddrW     = $clog2(MaxPoints);
    localparam int CountW    = $clog2(MaxPoints + 1);
    localparam int DataW     = 32;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        MODE_LINEAR  = 2'd0,
        MODE_UPPER   = 2'd1,
        MODE_LOWER   = 2'd2,
        MODE_CLOSEST = 2'd3
    } mode_t;

    // Request to the serial divider.
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [32:0] divisor;
    } div_req_t;

    // Response from the serial divider.
    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

endpackage

/* rtl/kci_ram.sv */
// Generic single-port RAM with registered read data.
module kci_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* rtl/kci_div.sv */
// Restoring bit-serial unsigned divider, 64-bit dividend by 33-bit divisor.
module kci_div (
    input  logic              clk,
    input  logic              rst_n,
    input  kci_pkg::div_req_t req,
    output kci_pkg::div_rsp_t rsp
);

    logic [63:0] quot_reg, quot_next;
    logic [33:0] rem_reg, rem_next;
    logic [32:0] dvs_reg, dvs_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [33:0] shifted;
    logic [33:0] diff;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[32:0], quot_reg[63]};
        diff      = shifted - {1'b0, dvs_reg};
        if (req.start)
        begin
            quot_next = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle
            if (!diff[33])
            begin
                rem_next  = diff;
                quot_next = {quot_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted;
                quot_next = {quot_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without prior busy");
    a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
        !(done_reg && busy_reg))
        else $error("divider done while busy");
    a_cnt_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) && !$past(req.start) |-> done_reg)
        else $error("divider stopped without done");

endmodule

/* rtl/keyframe_curve_interpolator.sv */
// Top level of the keyframe curve interpolator.
// Usage: raise start with opcode, point_x, point_y and right_side while busy
// is low; the transaction is taken at that edge and busy rises. Exactly one
// result follows, shown for one cycle with done high on curve_value,
// curve_slope, status and point_count; the receiver cannot stall it.
// A new transaction can be taken in the cycle that shows done.
// interp_mode is written over cfg_valid/cfg_ready/cfg_data; cfg_ready is
// high only while the block is idle.
// Insert and query do a binary search of log2(count)+1 reads of the key
// memory. An insert then shifts the tail up one entry at a time, a read
// and a write per entry. A query reads its two neighbors and runs up to
// two serial divisions for value and slope.
// Reset empties the table and sets linear mode; memory contents stay
// undefined, only entries below the count are ever used.
module keyframe_curve_interpolator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic        right_side,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    output logic        done,
    output logic signed [31:0] curve_value,
    output logic signed [31:0] curve_slope,
    output logic        status,
    output logic [6:0]  point_count
);

    localparam int AW = kci_pkg::AddrW;
    localparam int CW = kci_pkg::CountW;

    typedef enum logic [4:0] {
        S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_INS_DEC, S_SHIFT_RD, S_SHIFT_WR,
        S_INS_WR, S_Q_RD_A, S_Q_RD_B, S_Q_GOT, S_VAL_DIV, S_VAL_WAIT,
        S_SLP_RD_A, S_SLP_RD_B, S_SLP_GOT, S_SLP_WAIT, S_FINISH
    } state_t;

    state_t          state_reg, state_next;
    logic [1:0]      mode_reg, mode_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [1:0]      op_reg, op_next;
    logic signed [31:0] x_reg, x_next, y_reg, y_next;
    logic            side_reg, side_next;
    logic [CW-1:0]   lo_reg, lo_next, hi_reg, hi_next;
    logic [CW-1:0]   j_reg, j_next;
    logic            hit_reg, hit_next;
    logic signed [31:0] x1_reg, x1_next, y1_reg, y1_next;
    logic signed [31:0] x2_reg, x2_next, y2_reg, y2_next;
    logic signed [31:0] val_reg, val_next, slp_reg, slp_next;
    logic            neg_reg, neg_next;
    logic            done_reg, done_next, status_reg, status_next;
    logic [CW-1:0]   sa_reg, sa_next;

    logic            mem_we;
    logic [AW-1:0]   mem_addr;
    logic [31:0]     key_wdata, val_wdata, key_rdata, val_rdata;
    kci_pkg::div_req_t div_req;
    kci_pkg::div_rsp_t div_rsp;

    logic [CW-1:0]   mid;
    logic signed [32:0] dx, dy, t;
    logic [32:0]     dy_mag;
    logic [63:0]     prod;
    logic signed [33:0] lin;
    logic [63:0]     q_sat;

    kci_ram #(.Width(32), .Depth(kci_pkg::MaxPoints)) u_key_ram (
        .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(key_wdata), .rdata(key_rdata));
    kci_ram #(.Width(32), .Depth(kci_pkg::MaxPoints)) u_val_ram (
        .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(val_wdata), .rdata(val_rdata));
    kci_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

    assign mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign dx     = {x2_reg[31], x2_reg} - {x1_reg[31], x1_reg};
    assign dy     = {y2_reg[31], y2_reg} - {y1_reg[31], y1_reg};
    assign t      = {x_reg[31], x_reg} - {x1_reg[31], x1_reg};
    assign dy_mag = dy[32] ? 33'(-dy) : 33'(dy);
    assign prod   = 64'(t[31:0]) * 64'(dy_mag[31:0]) + (dy_mag[32] ? {t[31:0], 32'h0} : 64'h0);
    assign q_sat  = (div_rsp.quotient > 64'h8000_0000) ? 64'h8000_0000 : div_rsp.quotient;

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        count_next  = count_reg;
        op_next     = op_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        side_next   = side_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        j_next      = j_reg;
        hit_next    = hit_reg;
        x1_next     = x1_reg;
        y1_next     = y1_reg;
        x2_next     = x2_reg;
        y2_next     = y2_reg;
        val_next    = val_reg;
        slp_next    = slp_reg;
        neg_next    = neg_reg;
        sa_next     = sa_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        mem_we      = 1'b0;
        mem_addr    = mid[AW-1:0];
        key_wdata   = key_rdata;
        val_wdata   = val_rdata;
        div_req     = '0;
        lin         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid && cfg_ready)
                begin
                    mode_next = cfg_data;
                end
                if (start)
                begin
                    op_next     = opcode;
                    x_next      = point_x;
                    y_next      = point_y;
                    side_next   = right_side;
                    lo_next     = '0;
                    hi_next     = count_reg;
                    j_next      = '0;
                    hit_next    = 1'b0;
                    val_next    = '0;
                    slp_next    = '0;
                    status_next = 1'b0;
                    unique case (kci_pkg::opcode_t'(opcode)) inside
                        kci_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_FINISH;
                        end
                        kci_pkg::OP_INSERT, kci_pkg::OP_QUERY:
                            state_next = S_SRCH_RD;
                        default:
                            state_next = S_FINISH;
                    endcase
                end
            end
            S_SRCH_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    state_next = S_SRCH_CMP;
                end
                else if (op_reg == kci_pkg::OP_INSERT)
                begin
                    state_next = S_INS_DEC;
                end
                else
                begin
                    state_next = S_Q_RD_A;
                end
            end
            S_SRCH_CMP:
            begin
                if ($signed(key_rdata) < x_reg)
                begin
                    lo_next = mid + CW'(1);
                end
                else
                begin
                    hi_next = mid;
                    hit_next = ($signed(key_rdata) == x_reg);
                end
                state_next = S_SRCH_RD;
            end
            S_INS_DEC:
            begin
                // hit_reg holds the compare of the last probe that moved hi onto lo
                if (hit_reg)
                begin
                    state_next = S_INS_WR;
                end
                else if (count_reg == CW'(kci_pkg::MaxPoints))
                begin
                    status_next = 1'b1;
                    state_next  = S_FINISH;
                end
                else
                begin
                    j_next     = count_reg;
                    state_next = (count_reg > lo_reg) ? S_SHIFT_RD : S_INS_WR;
                end
            end
            S_SHIFT_RD:
            begin
                mem_addr   = AW'(j_reg - CW'(1));
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                mem_addr = j_reg[AW-1:0];
                mem_we   = 1'b1;
                j_next   = j_reg - CW'(1);
                state_next = (j_reg - CW'(1) > lo_reg) ? S_SHIFT_RD : S_INS_WR;
            end
            S_INS_WR:
            begin
                mem_addr  = lo_reg[AW-1:0];
                mem_we    = 1'b1;
                key_wdata = x_reg;
                val_wdata = y_reg;
                if (!hit_reg)
                begin
                    count_next = count_reg + CW'(1);
                end
                state_next = S_FINISH;
            end
            S_Q_RD_A:
            begin
                // read neighbor below (or the first entry when lo is zero)
                if (count_reg == '0)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    mem_addr   = (lo_reg == '0) ? '0 : AW'(lo_reg - CW'(1));
                    state_next = S_Q_RD_B;
                end
            end
            S_Q_RD_B:
            begin
                x1_next    = key_rdata;
                y1_next    = val_rdata;
                mem_addr   = (lo_reg >= count_reg) ? AW'(count_reg - CW'(1)) : lo_reg[AW-1:0];
                state_next = S_Q_GOT;
            end
            S_Q_GOT:
            begin
                x2_next = key_rdata;
                y2_next = val_rdata;
                if (lo_reg >= count_reg)
                begin
                    val_next   = val_rdata;
                    state_next = S_FINISH;
                end
                else if (hit_reg || lo_reg == '0)
                begin
                    val_next = val_rdata;
                    if (!hit_reg || count_reg == CW'(1))
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        if (lo_reg == '0 || (side_reg && lo_reg != count_reg - CW'(1)))
                        begin
                            sa_next = lo_reg;
                        end
                        else
                        begin
                            sa_next = lo_reg - CW'(1);
                        end
                        state_next = S_SLP_RD_A;
                    end
                end
                else
                begin
                    sa_next    = lo_reg - CW'(1);
                    state_next = S_VAL_DIV;
                end
            end
            S_VAL_DIV:
            begin
                unique case (kci_pkg::mode_t'(mode_reg))
                    kci_pkg::MODE_UPPER:
                    begin
                        val_next   = y2_reg;
                        state_next = S_SLP_GOT;
                    end
                    kci_pkg::MODE_LOWER:
                    begin
                        val_next   = y1_reg;
                        state_next = S_SLP_GOT;
                    end
                    kci_pkg::MODE_CLOSEST:
                    begin
                        val_next   = (t < ({x2_reg[31], x2_reg} - {x_reg[31], x_reg}))
                                     ? y1_reg : y2_reg;
                        state_next = S_SLP_GOT;
                    end
                    default:
                    begin
                        neg_next         = dy[32];
                        div_req.start    = 1'b1;
                        div_req.dividend = prod;
                        div_req.divisor  = dx;
                        state_next       = S_VAL_WAIT;
                    end
                endcase
            end
            S_VAL_WAIT:
            begin
                if (div_rsp.done)
                begin
                    lin = neg_reg ? 34'($signed(y1_reg)) - 34'(div_rsp.quotient[32:0])
                                  : 34'($signed(y1_reg)) + 34'(div_rsp.quotient[32:0]);
                    val_next   = lin[31:0];
                    state_next = S_SLP_GOT;
                end
            end
            S_SLP_RD_A:
            begin
                mem_addr   = sa_reg[AW-1:0];
                state_next = S_SLP_RD_B;
            end
            S_SLP_RD_B:
            begin
                x1_next    = key_rdata;
                y1_next    = val_rdata;
                mem_addr   = AW'(sa_reg + CW'(1));
                // next cycle fetch second point
                state_next = S_SLP_GOT;
                hit_next = 1'b0;
                sa_next  = sa_reg;
                j_next   = CW'(1);
            end
            S_SLP_GOT:
            begin
                // j flags that the second point arrives from memory this cycle
                if (j_reg == CW'(1))
                begin
                    x2_next = key_rdata;
                    y2_next = val_rdata;
                    j_next  = '0;
                end
                else
                begin
                    neg_next         = dy[32];
                    div_req.start    = 1'b1;
                    div_req.dividend = {15'h0, dy_mag, 16'h0};
                    div_req.divisor  = dx;
                    state_next       = S_SLP_WAIT;
                end
            end
            S_SLP_WAIT:
            begin
                if (div_rsp.done)
                begin
                    slp_next = neg_reg ? 32'(-q_sat[32:0]) : q_sat[31:0];
                    if (!neg_reg && q_sat[31])
                    begin
                        slp_next = 32'h7FFF_FFFF;
                    end
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mode_reg   <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= 1'b0;
            j_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            j_reg      <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        side_reg <= side_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        hit_reg  <= hit_next;
        x1_reg   <= x1_next;
        y1_reg   <= y1_next;
        x2_reg   <= x2_next;
        y2_reg   <= y2_next;
        val_reg  <= val_next;
        slp_reg  <= slp_next;
        neg_reg  <= neg_next;
        sa_reg   <= sa_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign cfg_ready   = (state_reg == S_IDLE) && !start;
    assign done        = done_reg;
    assign curve_value = done_reg ? val_reg : '0;
    assign curve_slope = done_reg ? slp_reg : '0;
    assign status      = status_reg & done_reg;
    assign point_count = 7'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(kci_pkg::MaxPoints))
        else $error("point count above capacity");
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |->
            count_reg == '0 || count_reg == $past(count_reg) + CW'(1))
        else $error("count changed by more than one");
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> busy)
        else $error("memory written while idle");

endmodule
